// ===== src/mtg_pkg.sv =====
// ---------------------------------------------------------------------------
// mtg_pkg: shared types and constants of the monochrome text/graphics pixel
// generator.
// Holds render kinds, operation codes, mode and attribute codes, and the
// address wrap helper used by the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

  // Operation codes carried in s_tuser.
  localparam logic [1:0] OP_VRAM_WR = 2'd0;
  localparam logic [1:0] OP_FONT_WR = 2'd1;
  localparam logic [1:0] OP_RENDER  = 2'd2;
  localparam logic [1:0] OP_VSYNC   = 2'd3;

  // Mode register decoding.
  localparam logic [7:0] MODE_SEL_MASK = 8'h2A;
  localparam logic [7:0] MODE_TEXT     = 8'h08;
  localparam logic [7:0] MODE_BLINK    = 8'h28;
  localparam logic [7:0] MODE_GFX      = 8'h0A;
  localparam logic [7:0] MODE_GFX_ALT  = 8'h2A;

  // Attribute codes with reverse video.
  localparam logic [7:0] ATTR_REV       = 8'h70;
  localparam logic [7:0] ATTR_REV_HI    = 8'h78;
  localparam logic [7:0] ATTR_REV_BL    = 8'hF0;
  localparam logic [7:0] ATTR_REV_BL_HI = 8'hF8;
  localparam logic [7:0] ATTR_GLYPH_MASK = 8'h77;
  localparam logic [2:0] ATTR_UNDERLINE  = 3'b001;

  // Character codes C0h..DFh repeat their last column.
  localparam logic [7:0] CHR_NINTH_MASK = 8'hE0;
  localparam logic [7:0] CHR_NINTH_CODE = 8'hC0;

  // Palette indices.
  localparam logic [1:0] PAL_BLACK   = 2'd0;
  localparam logic [1:0] PAL_DIM     = 2'd1;
  localparam logic [1:0] PAL_NORMAL  = 2'd2;
  localparam logic [1:0] PAL_INTENSE = 2'd3;

  // Valid pixel counts.
  localparam logic [4:0] PIX_COUNT_OFF  = 5'd0;
  localparam logic [4:0] PIX_COUNT_TEXT = 5'd9;
  localparam logic [4:0] PIX_COUNT_GFX  = 5'd16;

  // Stream widths.
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;

  localparam int OUT_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    RK_OFF,
    RK_TEXT,
    RK_BLINK,
    RK_GFX
  } render_kind_t;

  // Per-cell control that follows a render item through the pipeline.
  typedef struct packed {
    render_kind_t kind;
    logic         cursor;
    logic [1:0]   frame_bits;  // frame counter bits 4:3
    logic         ninth;       // character code repeats its last column
  } cell_ctrl_t;

  typedef struct packed {
    logic [31:0] pixels;
    logic [4:0]  pixel_count;
  } pix_item_t;

  // Reduces a 16-bit address modulo a store depth of at least 4096, so the
  // quotient never exceeds 16 and a row of constant compares finds it.
  function automatic logic [15:0] wrap_addr(input logic [15:0] a, input int unsigned depth);
    logic [15:0] r;
    r = a;
    for (int k = 1; k <= 16; k++) begin
      if (32'(a) >= 32'(k) * depth) begin
        r = a - 16'(32'(k) * depth);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/mono_text_graphics_pixel_gen.sv =====
// A render item passes the video RAM read, the font read and the result queue before it is presented.
// Throughput: one item per cycle while s_tready is high, set by the two-port video RAM read
// followed by the font read. Write and vertical-sync items produce no result.
// Reset clears the mode register, the frame counter, the pipeline and the result queue.
// Video RAM and font store are not cleared; an entry reads valid only once written.
// ---------------------------------------------------------------------------
// mono_text_graphics_pixel_gen: monochrome text and graphics cell generator.
// Keeps video RAM and font store, advances a frame counter on vertical sync,
// and turns render items into pixel items through a two-stage memory pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module mono_text_graphics_pixel_gen #(
  parameter int VIDEO_RAM_DEPTH = 65536,
  parameter int FONT_DEPTH      = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [7:0]                      cfg_wdata,   // mode register
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [15:0] address, [23:16] write_data, [28:24] row_in_char, [29] cursor_here
  input  wire logic [mtg_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic [mtg_pkg::S_TUSER_W-1:0]   s_tuser,     // [1:0] operation
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [mtg_pkg::M_TDATA_W-1:0]        m_tdata      // [31:0] pixels, [36:32] pixel_count
);

  localparam int VA_W = $clog2(VIDEO_RAM_DEPTH);
  localparam int FA_W = $clog2(FONT_DEPTH);
  localparam int QC_W = $clog2(mtg_pkg::OUT_QUEUE_DEPTH + 1);

  logic [7:0]  mode_reg;
  logic [4:0]  frame_count;

  logic        accept;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [4:0]  row_in_char;
  logic        cursor_here;

  mtg_pkg::render_kind_t kind;
  logic [15:0] gfx_addr0;
  logic [15:0] rd_addr0;
  logic [15:0] rd_addr1;
  logic [15:0] wrap0;
  logic [15:0] wrap1;
  logic [15:0] vram_wr_wrap;
  logic [15:0] font_wr_wrap;

  logic [7:0]  vram_rd0;
  logic [7:0]  vram_rd1;
  logic [7:0]  font_rd;
  logic [11:0] font_sum;

  logic                p1_valid;
  mtg_pkg::cell_ctrl_t p1_ctrl;
  mtg_pkg::cell_ctrl_t p1_ctrl_next;
  logic [4:0]          p1_row;
  logic                p2_valid;
  mtg_pkg::cell_ctrl_t p2_ctrl;
  mtg_pkg::cell_ctrl_t p2_ctrl_next;
  logic [7:0]          p2_hi;
  logic [7:0]          p2_lo;

  mtg_pkg::pix_item_t  fmt_item;
  mtg_pkg::pix_item_t  head_item;
  logic [QC_W-1:0]     q_count;

  assign operation   = s_tuser[1:0];
  assign address     = s_tdata[15:0];
  assign write_data  = s_tdata[23:16];
  assign row_in_char = s_tdata[28:24];
  assign cursor_here = s_tdata[29];

  // Every render in flight has a queue slot reserved, so the pipeline never stalls.
  assign s_tready = (int'(q_count) + int'(p1_valid) + int'(p2_valid))
                    < mtg_pkg::OUT_QUEUE_DEPTH;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    unique case (mode_reg & mtg_pkg::MODE_SEL_MASK) inside
      mtg_pkg::MODE_TEXT:                       kind = mtg_pkg::RK_TEXT;
      mtg_pkg::MODE_BLINK:                      kind = mtg_pkg::RK_BLINK;
      mtg_pkg::MODE_GFX, mtg_pkg::MODE_GFX_ALT: kind = mtg_pkg::RK_GFX;
      default:                                  kind = mtg_pkg::RK_OFF;
    endcase
  end

  // Graphics reads two bytes of the selected page and scanline bank; text
  // reads the character and its attribute inside a 4 KB window.
  assign gfx_addr0 = {mode_reg[7], row_in_char[1:0], 13'd0} + {address[14:0], 1'b0};

  always_comb begin
    if (kind == mtg_pkg::RK_GFX) begin
      rd_addr0 = gfx_addr0;
      rd_addr1 = gfx_addr0 + 16'd1;
    end else begin
      rd_addr0 = {4'd0, address[10:0], 1'b0};
      rd_addr1 = {4'd0, address[10:0], 1'b1};
    end
  end

  assign wrap0        = mtg_pkg::wrap_addr(rd_addr0, VIDEO_RAM_DEPTH);
  assign wrap1        = mtg_pkg::wrap_addr(rd_addr1, VIDEO_RAM_DEPTH);
  assign vram_wr_wrap = mtg_pkg::wrap_addr(address, VIDEO_RAM_DEPTH);
  assign font_wr_wrap = mtg_pkg::wrap_addr(address, FONT_DEPTH);

  mtg_ram #(
    .WIDTH (8),
    .DEPTH (VIDEO_RAM_DEPTH)
  ) u_vram (
    .clk     (clk),
    .we      (accept && operation == mtg_pkg::OP_VRAM_WR),
    .waddr   (vram_wr_wrap[VA_W-1:0]),
    .wdata   (write_data),
    .raddr_a (wrap0[VA_W-1:0]),
    .rdata_a (vram_rd0),
    .raddr_b (wrap1[VA_W-1:0]),
    .rdata_b (vram_rd1)
  );

  // Font row: scanlines 8..15 and 24..31 come from the upper half of the store.
  assign font_sum = (p1_row[3] ? {1'b1, 8'd0, p1_row[2:0]} : {7'd0, p1_row})
                    + {1'b0, vram_rd0, 3'd0};

  // A font write accepted in the same cycle as this read is younger than the
  // render, so the read-first RAM returns the older byte as required.
  mtg_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk     (clk),
    .we      (accept && operation == mtg_pkg::OP_FONT_WR),
    .waddr   (font_wr_wrap[FA_W-1:0]),
    .wdata   (write_data),
    .raddr_a (FA_W'(font_sum)),
    .rdata_a (font_rd),
    .raddr_b (FA_W'(font_sum)),
    .rdata_b ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= '0;
      frame_count <= '0;
      p1_valid    <= 1'b0;
      p2_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        mode_reg <= cfg_wdata;
      end
      if (accept && operation == mtg_pkg::OP_VSYNC) begin
        frame_count <= frame_count + 5'd1;
      end
      p1_valid <= accept && operation == mtg_pkg::OP_RENDER;
      p2_valid <= p1_valid;
    end
  end

  // The ninth-column flag is known only once the character code is read.
  always_comb begin
    p1_ctrl_next.kind       = kind;
    p1_ctrl_next.cursor     = cursor_here;
    p1_ctrl_next.frame_bits = frame_count[4:3];
    p1_ctrl_next.ninth      = 1'b0;

    p2_ctrl_next       = p1_ctrl;
    p2_ctrl_next.ninth = (vram_rd0 & mtg_pkg::CHR_NINTH_MASK) == mtg_pkg::CHR_NINTH_CODE;
  end

  always_ff @(posedge clk) begin
    p1_ctrl <= p1_ctrl_next;
    p1_row  <= row_in_char;

    p2_ctrl <= p2_ctrl_next;
    p2_hi   <= vram_rd0;
    p2_lo   <= vram_rd1;
  end

  mtg_pixel_fmt u_fmt (
    .ctrl      (p2_ctrl),
    .attr      (p2_lo),
    .font_byte (font_rd),
    .gfx_bits  ({p2_hi, p2_lo}),
    .item      (fmt_item)
  );

  mtg_out_queue #(
    .DEPTH (mtg_pkg::OUT_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (p2_valid),
    .push_item (fmt_item),
    .pop       (m_tvalid && m_tready),
    .head_item (head_item),
    .count     (q_count)
  );

  assign m_tvalid = (q_count != '0);
  assign m_tdata  = {3'd0, head_item.pixel_count, head_item.pixels};

  // The reservation scheme must keep the queue from ever overfilling.
  assert property (@(posedge clk) disable iff (rst)
    (int'(q_count) + int'(p1_valid) + int'(p2_valid)) <= mtg_pkg::OUT_QUEUE_DEPTH)
    else $error("result queue over-reserved");

  assert property (@(posedge clk) disable iff (rst)
    (accept && operation == mtg_pkg::OP_RENDER) |=> ##1 p2_valid)
    else $error("render item lost in pipeline");

  assert property (@(posedge clk) disable iff (rst)
    (accept && operation == mtg_pkg::OP_VSYNC) |=> frame_count == $past(frame_count) + 5'd1)
    else $error("frame counter did not advance on vertical sync");

  assert property (@(posedge clk) disable iff (rst)
    (p2_valid && q_count == '0) |=> m_tvalid)
    else $error("finished result not presented");

endmodule

`default_nettype wire

// ===== src/mtg_ram.sv =====
// ---------------------------------------------------------------------------
// mtg_ram: generic synchronous RAM.
// One write port and two read ports, read data registered, read-first on a
// same-address write.
// ---------------------------------------------------------------------------
`default_nettype none

module mtg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== src/mtg_pixel_fmt.sv =====
// ---------------------------------------------------------------------------
// mtg_pixel_fmt: cell pixel formatter.
// Applies the text attribute rules or expands a graphics word into two-bit
// palette pixels, leftmost pixel in the top bits; an off cell yields no pixels.
// ---------------------------------------------------------------------------
`default_nettype none

module mtg_pixel_fmt (
  input  wire mtg_pkg::cell_ctrl_t ctrl,
  input  wire logic [7:0]          attr,
  input  wire logic [7:0]          font_byte,
  input  wire logic [15:0]         gfx_bits,
  output mtg_pkg::pix_item_t       item
);

  logic [7:0]  data;
  logic [1:0]  fg;
  logic [1:0]  bg;
  logic [1:0]  ninth_px;
  logic        blink;
  logic [31:0] text_px;
  logic [31:0] gfx_px;

  assign blink = (ctrl.kind == mtg_pkg::RK_BLINK);

  always_comb begin
    data = font_byte;
    if ((attr & mtg_pkg::ATTR_GLYPH_MASK) == 8'h00) begin
      data = 8'h00;
    end

    fg = attr[3] ? mtg_pkg::PAL_INTENSE : mtg_pkg::PAL_NORMAL;
    bg = mtg_pkg::PAL_BLACK;
    case (attr)
      mtg_pkg::ATTR_REV: begin
        bg = mtg_pkg::PAL_NORMAL;
        fg = mtg_pkg::PAL_BLACK;
      end
      mtg_pkg::ATTR_REV_HI: begin
        bg = mtg_pkg::PAL_NORMAL;
        fg = mtg_pkg::PAL_DIM;
      end
      mtg_pkg::ATTR_REV_BL: begin
        bg = blink ? mtg_pkg::PAL_NORMAL : mtg_pkg::PAL_INTENSE;
        fg = mtg_pkg::PAL_BLACK;
      end
      mtg_pkg::ATTR_REV_BL_HI: begin
        bg = blink ? mtg_pkg::PAL_NORMAL : mtg_pkg::PAL_INTENSE;
        fg = mtg_pkg::PAL_DIM;
      end
      default: begin
      end
    endcase

    // Frame bit 1 of frame_bits is counter bit 4 (blink), bit 0 is bit 3 (cursor).
    if (blink) begin
      if (attr[2:0] == mtg_pkg::ATTR_UNDERLINE) begin
        data = 8'hFF;
      end
      if (ctrl.cursor) begin
        if (ctrl.frame_bits[0]) begin
          data = 8'hFF;
        end
      end else if (attr[7] && ctrl.frame_bits[1]) begin
        data = 8'h00;
      end
    end else begin
      if ((ctrl.cursor && ctrl.frame_bits[0]) || attr[2:0] == mtg_pkg::ATTR_UNDERLINE) begin
        data = 8'hFF;
      end
    end

    ninth_px = ctrl.ninth ? (data[0] ? fg : bg) : bg;

    text_px = '0;
    for (int i = 0; i < 8; i++) begin
      text_px[31-2*i -: 2] = data[7-i] ? fg : bg;
    end
    text_px[15:14] = ninth_px;

    gfx_px = '0;
    for (int i = 0; i < 16; i++) begin
      gfx_px[31-2*i -: 2] = gfx_bits[15-i] ? mtg_pkg::PAL_NORMAL : mtg_pkg::PAL_BLACK;
    end
  end

  always_comb begin
    unique case (ctrl.kind)
      mtg_pkg::RK_TEXT, mtg_pkg::RK_BLINK: begin
        item.pixels      = text_px;
        item.pixel_count = mtg_pkg::PIX_COUNT_TEXT;
      end
      mtg_pkg::RK_GFX: begin
        item.pixels      = gfx_px;
        item.pixel_count = mtg_pkg::PIX_COUNT_GFX;
      end
      default: begin
        item.pixels      = '0;
        item.pixel_count = mtg_pkg::PIX_COUNT_OFF;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/mtg_out_queue.sv =====
// ---------------------------------------------------------------------------
// mtg_out_queue: result queue.
// Small register FIFO that holds finished pixel items until the output side
// takes them.
// ---------------------------------------------------------------------------
`default_nettype none

module mtg_out_queue #(
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire mtg_pkg::pix_item_t push_item,
  input  wire logic               pop,
  output mtg_pkg::pix_item_t      head_item,
  output logic [CW-1:0]           count
);

  mtg_pkg::pix_item_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
